/* sv/scp_pkg.sv */
// Types and constants shared by the serial channel command parser.
package scp_pkg;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_CHAN   = 3'd1,
		PH_MSB    = 3'd2,
		PH_LSB    = 3'd3,
		PH_CFIRST = 3'd4,
		PH_CMD    = 3'd5,
		PH_SKIP   = 3'd6
	} phase_t;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_DONE = 2'd2;

	localparam logic [7:0] TOK_C = 8'h43;
	localparam logic [7:0] TOK_T = 8'h54;
	localparam logic [7:0] TOK_F = 8'h46;

	localparam logic [7:0] TIMEOUT_RESET = 8'd10;
	localparam logic [7:0] IDLE_MAX      = 8'hFF;
	localparam logic [2:0] SKIP_OOB      = 3'd2;
	localparam logic [2:0] SKIP_PENDING  = 3'd4;
	localparam logic [2:0] CMD_LAST_POS  = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
		logic       key_pressed;
	} item_t;

	typedef struct packed {
		logic        ack_out;
		logic        chan_write;
		logic [2:0]  chan_index;
		logic [15:0] chan_value;
		logic        group_sync;
		logic        count_update;
		logic [3:0]  channel_count;
		logic        cmd_byte_valid;
		logic [2:0]  cmd_byte_pos;
		logic [7:0]  cmd_byte_data;
		logic        cmd_complete;
		logic        flash_request;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] held_msb;
		logic [2:0] byte_counter;
		logic       command_pending;
		logic [7:0] idle_ticks;
	} parse_state_t;

endpackage

/* sv/serial_channel_command_parser.sv */
// Top level of the serial channel command parser: handshakes, state and result registers.
//
//  channel  | handshake                | payload
//  item     | item_valid / item_stall  | item (item_t): cmd, rx_byte, key_pressed
//  result   | result_valid / result_stall | result (result_t): one per item
//  cfg      | cfg_valid / cfg_ready    | cfg_data: timeout_ticks
//
// One request per cycle sustained unless result_stall holds; registers: item_s1, then res_q.
// The whole parse step is one pass of logic between item_s1 and res_q.
// Reset clears the parser state and sets timeout_ticks to 10; no clearing pass.
// A stalled result holds in res_q; one more request waits in item_s1, then item_stall rises.
module serial_channel_command_parser
	import scp_pkg::*;
#(
	parameter int CHANNEL_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int CH_W = (CHANNEL_SLOTS > 2) ? $clog2(CHANNEL_SLOTS) : 1;

	logic            valid_s1;
	item_t           item_s1;
	logic            res_valid_q;
	result_t         res_q;
	parse_state_t    st_q;
	logic [CH_W-1:0] held_q;
	logic [7:0]      timeout_q;

	parse_state_t    st_nxt;
	logic [CH_W-1:0] held_nxt;
	result_t         step_res;
	logic            s1_fire;
	logic            item_take;

	assign s1_fire      = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !s1_fire;
	assign item_take    = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	scp_step #(
		.CHANNEL_SLOTS(CHANNEL_SLOTS),
		.CH_W(CH_W)
	) u_step (
		.item(item_s1),
		.timeout_ticks(timeout_q),
		.st(st_q),
		.held(held_q),
		.st_nxt(st_nxt),
		.held_nxt(held_nxt),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			st_q        <= '{phase: PH_WAIT, default: '0};
			held_q      <= '0;
			timeout_q   <= TIMEOUT_RESET;
		end else begin
			if (item_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				res_valid_q <= 1'b1;
				st_q        <= st_nxt;
				held_q      <= held_nxt;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
		if (s1_fire) begin
			res_q <= step_res;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> (!valid_s1 || s1_fire))
		else $error("input register overwritten");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> res_valid_q)
		else $error("processed request produced no result");

	a_pending_set: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && step_res.cmd_complete |=> st_q.command_pending)
		else $error("completed command not marked pending");

	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_CMD |-> st_q.byte_counter <= CMD_LAST_POS)
		else $error("command byte count out of range");
`endif

endmodule

/* sv/scp_step.sv */
// Next-state and result logic of the parser for one request.
module scp_step
	import scp_pkg::*;
#(
	parameter int CHANNEL_SLOTS = 8,
	parameter int CH_W          = 3
) (
	input  item_t            item,
	input  logic [7:0]       timeout_ticks,
	input  parse_state_t     st,
	input  logic [CH_W-1:0]  held,
	output parse_state_t     st_nxt,
	output logic [CH_W-1:0]  held_nxt,
	output result_t          res
);

	localparam logic [7:0] SLOTS_B = 8'(CHANNEL_SLOTS);

	logic            is_byte;
	phase_t          eff_phase;
	logic            slot_oob;
	logic [CH_W-1:0] rx_ch;
	logic [2:0]      bc_inc;

	assign is_byte   = (item.cmd == CMD_BYTE);
	assign eff_phase = (st.idle_ticks >= timeout_ticks) ? PH_WAIT : st.phase;
	assign slot_oob  = (item.rx_byte >= SLOTS_B);
	assign rx_ch     = item.rx_byte[CH_W-1:0];
	assign bc_inc    = st.byte_counter + 3'd1;

	// next state
	always_comb begin
		st_nxt   = st;
		held_nxt = held;
		unique case (item.cmd)
			CMD_BYTE: begin
				st_nxt.idle_ticks = '0;
				st_nxt.phase      = eff_phase;
				unique case (eff_phase)
					PH_CHAN: begin
						if (slot_oob) begin
							st_nxt.byte_counter = SKIP_OOB;
							st_nxt.phase        = PH_SKIP;
						end else begin
							held_nxt     = rx_ch;
							st_nxt.phase = PH_MSB;
						end
					end
					PH_MSB: begin
						st_nxt.held_msb = item.rx_byte;
						st_nxt.phase    = PH_LSB;
					end
					PH_LSB: begin
						st_nxt.phase = PH_WAIT;
					end
					PH_CFIRST: begin
						if (st.command_pending) begin
							st_nxt.byte_counter = SKIP_PENDING;
							st_nxt.phase        = PH_SKIP;
						end else begin
							st_nxt.byte_counter = '0;
							st_nxt.phase        = PH_CMD;
						end
					end
					PH_CMD: begin
						if (bc_inc > CMD_LAST_POS) begin
							st_nxt.command_pending = 1'b1;
							st_nxt.byte_counter    = '0;
							st_nxt.phase           = PH_WAIT;
						end else begin
							st_nxt.byte_counter = bc_inc;
						end
					end
					PH_SKIP: begin
						if (st.byte_counter <= 3'd1) begin
							st_nxt.byte_counter = '0;
							st_nxt.phase        = PH_WAIT;
						end else begin
							st_nxt.byte_counter = st.byte_counter - 3'd1;
						end
					end
					default: begin
						st_nxt.phase = PH_WAIT;
						if (item.rx_byte == TOK_C) begin
							st_nxt.phase = PH_CHAN;
						end else if (item.rx_byte == TOK_T) begin
							st_nxt.phase = PH_CFIRST;
						end
					end
				endcase
			end
			CMD_TICK: begin
				if (st.idle_ticks != IDLE_MAX) begin
					st_nxt.idle_ticks = st.idle_ticks + 8'd1;
				end
			end
			CMD_DONE: begin
				st_nxt.command_pending = 1'b0;
			end
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		res = '0;
		if (is_byte) begin
			unique case (eff_phase)
				PH_CHAN: begin
					res.ack_out = 1'b1;
					if (!slot_oob && (rx_ch < held)) begin
						res.count_update  = 1'b1;
						res.channel_count = 4'({1'b0, held} + (CH_W+1)'(1));
					end
				end
				PH_MSB: ;
				PH_LSB: begin
					res.ack_out    = 1'b1;
					res.chan_write = 1'b1;
					res.chan_index = 3'(held);
					res.chan_value = {st.held_msb, item.rx_byte};
					res.group_sync = (32'(held) == 32'd3);
				end
				PH_CFIRST: begin
					if (!st.command_pending) begin
						res.cmd_byte_valid = 1'b1;
						res.cmd_byte_data  = item.rx_byte;
					end
				end
				PH_CMD: begin
					res.ack_out        = !st.byte_counter[0];
					res.cmd_byte_valid = 1'b1;
					res.cmd_byte_pos   = bc_inc;
					res.cmd_byte_data  = item.rx_byte;
					res.cmd_complete   = (bc_inc > CMD_LAST_POS);
				end
				PH_SKIP: ;
				default: begin
					res.flash_request = (item.rx_byte == TOK_F) && item.key_pressed;
				end
			endcase
		end
	end

endmodule

/* sim/tb_serial_channel_command_parser.sv */
// Testbench for the serial channel command parser: directed frames, then random traffic, all checked.
`timescale 1ns / 100ps

module tb_serial_channel_command_parser;
	import scp_pkg::*;

	localparam int         CHANNEL_SLOTS = 8;
	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam logic [2:0] SYNC_CHANNEL  = 3'd3;
	localparam logic [7:0] ECHO_A        = 8'h41;
	localparam int         DRAIN_LIMIT   = 20000;
	localparam int         RANDOM_ITEMS  = 450;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	// predicted parser state
	phase_t     ph;
	logic [2:0] cur_chan;
	logic [7:0] last_msb;
	logic [2:0] bytes_left;
	logic       cmd_waiting;
	logic [7:0] quiet_ticks;
	logic [7:0] tick_limit;

	result_t expected_results[$];
	int      errors = 0;
	int      items_sent = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      hold_target = 0;
	int      hold_count = 0;

	serial_channel_command_parser #(
		.CHANNEL_SLOTS(CHANNEL_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("tb_serial_channel_command_parser NOT OK");
		$finish;
	end

	function automatic result_t parse_step(item_t it);
		result_t r;
		logic [7:0] b;
		r = '0;
		b = it.rx_byte;
		case (it.cmd)
			CMD_BYTE: begin
				if (quiet_ticks >= tick_limit)
					ph = PH_WAIT;
				quiet_ticks = '0;
				case (ph)
					PH_CHAN: begin
						r.ack_out = 1'b1;
						if (b >= 8'(CHANNEL_SLOTS)) begin
							bytes_left = SKIP_OOB;
							ph = PH_SKIP;
						end else begin
							if (b[2:0] < cur_chan) begin
								r.count_update = 1'b1;
								r.channel_count = {1'b0, cur_chan} + 4'd1;
							end
							cur_chan = b[2:0];
							ph = PH_MSB;
						end
					end
					PH_MSB: begin
						last_msb = b;
						ph = PH_LSB;
					end
					PH_LSB: begin
						r.ack_out = 1'b1;
						r.chan_write = 1'b1;
						r.chan_index = cur_chan;
						r.chan_value = {last_msb, b};
						r.group_sync = (cur_chan == SYNC_CHANNEL);
						ph = PH_WAIT;
					end
					PH_CFIRST: begin
						if (cmd_waiting) begin
							bytes_left = SKIP_PENDING;
							ph = PH_SKIP;
						end else begin
							r.cmd_byte_valid = 1'b1;
							r.cmd_byte_pos = '0;
							r.cmd_byte_data = b;
							bytes_left = '0;
							ph = PH_CMD;
						end
					end
					PH_CMD: begin
						r.ack_out = ~bytes_left[0];
						r.cmd_byte_valid = 1'b1;
						r.cmd_byte_pos = bytes_left + 3'd1;
						r.cmd_byte_data = b;
						bytes_left = bytes_left + 3'd1;
						if (bytes_left > CMD_LAST_POS) begin
							cmd_waiting = 1'b1;
							r.cmd_complete = 1'b1;
							bytes_left = '0;
							ph = PH_WAIT;
						end
					end
					PH_SKIP: begin
						if (bytes_left <= 3'd1) begin
							bytes_left = '0;
							ph = PH_WAIT;
						end else
							bytes_left = bytes_left - 3'd1;
					end
					default: begin
						ph = PH_WAIT;
						if (b == TOK_C)
							ph = PH_CHAN;
						else if (b == TOK_T)
							ph = PH_CFIRST;
						else if (b == TOK_F && it.key_pressed)
							r.flash_request = 1'b1;
					end
				endcase
			end
			CMD_TICK: begin
				if (quiet_ticks != IDLE_MAX)
					quiet_ticks = quiet_ticks + 8'd1;
			end
			CMD_DONE: cmd_waiting = 1'b0;
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0)
				report_error("result with no request outstanding");
			else begin
				want = expected_results.pop_front();
				check_field("ack_out", 16'(result.ack_out), 16'(want.ack_out));
				check_field("chan_write", 16'(result.chan_write), 16'(want.chan_write));
				check_field("chan_index", 16'(result.chan_index), 16'(want.chan_index));
				check_field("chan_value", result.chan_value, want.chan_value);
				check_field("group_sync", 16'(result.group_sync), 16'(want.group_sync));
				check_field("count_update", 16'(result.count_update),
					16'(want.count_update));
				check_field("channel_count", 16'(result.channel_count),
					16'(want.channel_count));
				check_field("cmd_byte_valid", 16'(result.cmd_byte_valid),
					16'(want.cmd_byte_valid));
				check_field("cmd_byte_pos", 16'(result.cmd_byte_pos),
					16'(want.cmd_byte_pos));
				check_field("cmd_byte_data", 16'(result.cmd_byte_data),
					16'(want.cmd_byte_data));
				check_field("cmd_complete", 16'(result.cmd_complete),
					16'(want.cmd_complete));
				check_field("flash_request", 16'(result.flash_request),
					16'(want.flash_request));
			end
		end
	end

	// receiver: long hold-offs on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_count < hold_target) begin
			result_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else
			result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_item(input item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		expected_results.push_back(parse_step(it));
		if (it.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic k);
		item_t it;
		it.cmd = CMD_BYTE;
		it.rx_byte = b;
		it.key_pressed = k;
		send_item(it);
	endtask

	task automatic send_cmd(input logic [1:0] c);
		item_t it;
		it.cmd = c;
		it.rx_byte = 8'($urandom_range(255));
		it.key_pressed = 1'($urandom_range(1));
		send_item(it);
	endtask

	task automatic wait_results_drained();
		int n;
		n = 0;
		if (item_valid)
			item_valid <= 1'b0;
		while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (expected_results.size() != 0) begin
			report_error($sformatf("%0d results never arrived", expected_results.size()));
			expected_results.delete();
		end
	endtask

	task automatic write_timeout(input logic [7:0] v);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tick_limit = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_channel_frames();
		send_byte(TOK_C, 1'b0);
		send_byte(8'd0, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(TOK_C, 1'b1);
		send_byte(8'd7, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		// falling index, channel 3 raises sync
		send_byte(TOK_C, 1'b0);
		send_byte(8'd3, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		// index out of range, next two bytes dropped
		send_byte(TOK_C, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(TOK_C, 1'b0);
		send_byte(TOK_T, 1'b0);
		send_byte(TOK_C, 1'b0);
		send_byte(8'd8, 1'b0);
		wait_results_drained();
	endtask

	task automatic test_command_frames();
		send_byte(TOK_T, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		// command still pending: four-byte skip
		send_byte(TOK_T, 1'b0);
		repeat (5) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		send_cmd(CMD_DONE);
		send_byte(TOK_T, 1'b0);
		repeat (6) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		send_cmd(CMD_DONE);
		wait_results_drained();
	endtask

	task automatic test_flash_and_noise();
		send_byte(TOK_F, 1'b1);
		send_byte(TOK_F, 1'b0);
		send_byte(ECHO_A, 1'b1);
		send_cmd(CMD_UNUSED);
		send_cmd(CMD_TICK);
		send_byte(8'hFF, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_timeouts();
		write_timeout(8'd1);
		send_byte(TOK_C, 1'b0);
		send_cmd(CMD_TICK);
		send_byte(8'd2, 1'b0);
		write_timeout(8'd0);
		send_byte(TOK_C, 1'b0);
		send_byte(TOK_C, 1'b0);
		send_byte(8'd1, 1'b0);
		send_byte(TOK_T, 1'b0);
		send_byte(8'd5, 1'b0);
		// tick count saturates at 255, so 300 ticks still reach the limit of 255
		write_timeout(8'd255);
		send_byte(TOK_C, 1'b0);
		repeat (300) send_cmd(CMD_TICK);
		send_byte(8'd2, 1'b0);
		send_byte(TOK_C, 1'b0);
		repeat (254) send_cmd(CMD_TICK);
		send_byte(8'd2, 1'b0);
		write_timeout(TIMEOUT_RESET);
	endtask

	task automatic test_result_backpressure();
		wait_results_drained();
		send_idle_pct = 0;
		hold_target = hold_count + 200;
		repeat (10) begin
			send_byte(TOK_C, 1'b0);
			send_byte(8'($urandom_range(7)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b0);
		end
		wait_results_drained();
	endtask

	task automatic maybe_ticks();
		if ($urandom_range(99) < 12)
			repeat ($urandom_range(1, 4)) send_cmd(CMD_TICK);
	endtask

	task automatic send_random_sequence();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 35) begin
			send_byte(TOK_C, 1'($urandom_range(1)));
			maybe_ticks();
			if ($urandom_range(99) < 88)
				send_byte(8'($urandom_range(7)), 1'($urandom_range(1)));
			else
				send_byte(8'($urandom_range(CHANNEL_SLOTS, 255)), 1'($urandom_range(1)));
			maybe_ticks();
			send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
			maybe_ticks();
			send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		end else if (kind < 55) begin
			send_byte(TOK_T, 1'($urandom_range(1)));
			repeat (6) begin
				maybe_ticks();
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
			end
			if ($urandom_range(99) < 60)
				send_cmd(CMD_DONE);
		end else if (kind < 62)
			send_cmd(CMD_DONE);
		else if (kind < 70)
			send_byte(TOK_F, 1'($urandom_range(1)));
		else if (kind < 80) begin
			n = $urandom_range(1, 12);
			repeat (n) send_cmd(CMD_TICK);
		end else if (kind < 90)
			send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		else if (kind < 94)
			send_cmd(CMD_UNUSED);
		else begin
			// truncated frames
			send_byte($urandom_range(1) ? TOK_C : TOK_T, 1'($urandom_range(1)));
			repeat ($urandom_range(0, 3))
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input logic [7:0] limit);
		int target;
		write_timeout(limit);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target)
			send_random_sequence();
		wait_results_drained();
	endtask

	initial begin
		ph = PH_WAIT;
		cur_chan = '0;
		last_msb = '0;
		bytes_left = '0;
		cmd_waiting = 1'b0;
		quiet_ticks = '0;
		tick_limit = TIMEOUT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 20;
		recv_idle_pct = 20;
		test_channel_frames();
		test_command_frames();
		test_flash_and_noise();
		test_timeouts();
		test_result_backpressure();
		test_random_traffic(36, 72, TIMEOUT_RESET);
		test_random_traffic(72, 36, 8'($urandom_range(2, 8)));
		test_random_traffic(0, 0, 8'($urandom_range(1, 255)));
		wait_results_drained();
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("tb_serial_channel_command_parser OK");
		else
			$display("tb_serial_channel_command_parser NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
sv/scp_pkg.sv
sv/scp_step.sv
sv/serial_channel_command_parser.sv
sim/tb_serial_channel_command_parser.sv
